[src/cwsm_pkg.sv]
// Shared constants, codes and interface types for the concatenated-word matcher.
package cwsm_pkg;

  localparam int unsigned MaxWords    = 8;
  localparam int unsigned MaxWordLen  = 8;
  localparam int unsigned StoreDepth  = MaxWords * MaxWordLen;
  localparam int unsigned AddrW       = $clog2(StoreDepth);
  localparam int unsigned WordIdxW    = $clog2(MaxWords);
  localparam int unsigned ByteIdxW    = $clog2(MaxWordLen);
  localparam int unsigned MaxText     = 65536;
  localparam int unsigned TextPosW    = $clog2(MaxText) + 1;
  localparam int unsigned RegW        = 4;
  localparam int unsigned SpanW       = 2 * RegW;
  localparam int unsigned StartW      = 16;

  // Configuration register indexes.
  localparam logic RegWordLen   = 1'b0;
  localparam logic RegWordCount = 1'b1;

  typedef enum logic [1:0] {
    FuncWord         = 2'd0,
    FuncText         = 2'd1,
    FuncRestartText  = 2'd2,
    FuncRestartWord  = 2'd3
  } func_e;

  // Write side of the word store and the text window.
  typedef struct packed {
    logic             word_we;
    logic [AddrW-1:0] word_addr;
    logic             text_we;
    logic [AddrW-1:0] text_addr;
    logic [7:0]       wdata;
  } mem_wr_t;

  // Read addresses driven by the search sequencer.
  typedef struct packed {
    logic [AddrW-1:0] word_addr;
    logic [AddrW-1:0] text_addr;
  } mem_rd_t;

  // Registered read data returned to the sequencer.
  typedef struct packed {
    logic [7:0] word_byte;
    logic [7:0] text_byte;
  } mem_rdata_t;

endpackage

[src/concat_words_substring_match.sv]
// Top level: request handling, configuration, text position and result register.
//
//   channel  direction  handshake                  payload
//   in       input      in_valid_i / in_stall_o    func_i, ch_i
//   out      output     out_valid_o / out_stall_i  match_start_o
//   cfg      input      cfg_we_i                   cfg_idx_i, cfg_wdata_i
//
// Word bytes, restarts and text bytes that do not complete a window start no search.
// A text byte that completes a window runs the search sequencer, whose single byte
// comparator first reads each byte pair and then compares it; in_stall_o is high until
// the sequencer is idle again.
// A found match waits in the sequencer until the result register is free.
// Reset is asynchronous and active low; the word store and window are not cleared.
module concat_words_substring_match
  import cwsm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        func_i,
  input  logic [7:0]        ch_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [StartW-1:0] match_start_o,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [RegW-1:0]   cfg_wdata_i
);

  logic [RegW-1:0]     word_len_q, word_len_d;
  logic [RegW-1:0]     word_count_q, word_count_d;
  logic [AddrW-1:0]    load_ptr_q, load_ptr_d;
  logic [TextPosW-1:0] text_pos_q, text_pos_d;
  logic [StartW-1:0]   start_idx_q, start_idx_d;
  logic                out_valid_q, out_valid_d;
  logic [StartW-1:0]   out_data_q, out_data_d;

  logic                accept;
  func_e               func;
  logic [TextPosW-1:0] new_pos;
  logic [TextPosW-1:0] span;
  logic [TextPosW-1:0] start_pos;
  logic                text_ok;
  logic                launch;
  logic                seq_idle;
  logic                seq_match;
  logic                out_free;
  mem_wr_t             mem_wr;
  mem_rd_t             mem_rd;
  mem_rdata_t          mem_rdata;

  function automatic logic [RegW-1:0] clamp_reg(logic [RegW-1:0] v, logic [RegW-1:0] hi);
    logic [RegW-1:0] r;
    if (v == '0) begin
      r = RegW'(1);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  assign accept     = in_valid_i & ~in_stall_o;
  assign in_stall_o = ~seq_idle;
  assign func       = func_e'(func_i);

  assign span      = TextPosW'(SpanW'(word_len_q) * SpanW'(word_count_q));
  assign new_pos   = text_pos_q + TextPosW'(1);
  assign start_pos = new_pos - span;
  assign text_ok   = accept && (func == FuncText) && (text_pos_q < TextPosW'(MaxText));
  assign launch    = text_ok && (new_pos >= span);

  assign out_free = ~out_valid_q | ~out_stall_i;

  assign mem_wr.word_we   = accept && (func == FuncWord);
  assign mem_wr.word_addr = load_ptr_q;
  assign mem_wr.text_we   = text_ok;
  assign mem_wr.text_addr = text_pos_q[AddrW-1:0];
  assign mem_wr.wdata     = ch_i;

  always_comb begin
    word_len_d   = word_len_q;
    word_count_d = word_count_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegWordLen:   word_len_d   = clamp_reg(cfg_wdata_i, RegW'(MaxWordLen));
        RegWordCount: word_count_d = clamp_reg(cfg_wdata_i, RegW'(MaxWords));
        default:      ;
      endcase
    end
  end

  always_comb begin
    load_ptr_d  = load_ptr_q;
    text_pos_d  = text_pos_q;
    start_idx_d = start_idx_q;
    if (accept) begin
      unique case (func)
        FuncWord:        load_ptr_d = load_ptr_q + AddrW'(1);
        FuncText:        if (text_ok) text_pos_d = new_pos;
        FuncRestartText: text_pos_d = '0;
        FuncRestartWord: load_ptr_d = '0;
        default:         ;
      endcase
    end
    if (launch) begin
      start_idx_d = start_pos[StartW-1:0];
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (seq_match) begin
      out_valid_d = 1'b1;
      out_data_d  = start_idx_q;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_len_q   <= RegW'(1);
      word_count_q <= RegW'(1);
      load_ptr_q   <= '0;
      text_pos_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      word_len_q   <= word_len_d;
      word_count_q <= word_count_d;
      load_ptr_q   <= load_ptr_d;
      text_pos_q   <= text_pos_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_idx_q <= start_idx_d;
    out_data_q  <= out_data_d;
  end

  assign out_valid_o   = out_valid_q;
  assign match_start_o = out_data_q;

  cwsm_mem u_mem (
    .clk_i   (clk_i),
    .wr_i    (mem_wr),
    .rd_i    (mem_rd),
    .rdata_o (mem_rdata)
  );

  cwsm_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (launch),
    .base_i       (start_pos[AddrW-1:0]),
    .word_len_i   (word_len_q),
    .word_count_i (word_count_q),
    .rdata_i      (mem_rdata),
    .out_free_i   (out_free),
    .rd_o         (mem_rd),
    .idle_o       (seq_idle),
    .match_o      (seq_match)
  );

endmodule

[src/cwsm_mem.sv]
// Word store and circular text window, each with one write and one registered read port.
module cwsm_mem
  import cwsm_pkg::*;
(
  input  logic       clk_i,
  input  mem_wr_t    wr_i,
  input  mem_rd_t    rd_i,
  output mem_rdata_t rdata_o
);

  logic [7:0] word_mem [StoreDepth];
  logic [7:0] text_mem [StoreDepth];

  always_ff @(posedge clk_i) begin
    if (wr_i.word_we) begin
      word_mem[wr_i.word_addr] <= wr_i.wdata;
    end
    if (wr_i.text_we) begin
      text_mem[wr_i.text_addr] <= wr_i.wdata;
    end
    rdata_o.word_byte <= word_mem[rd_i.word_addr];
    rdata_o.text_byte <= text_mem[rd_i.text_addr];
  end

endmodule

[src/cwsm_seq.sv]
// Search sequencer: checks one window chunk by chunk against the word list with one byte comparator.
module cwsm_seq
  import cwsm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [AddrW-1:0] base_i,
  input  logic [RegW-1:0]  word_len_i,
  input  logic [RegW-1:0]  word_count_i,
  input  mem_rdata_t       rdata_i,
  input  logic             out_free_i,
  output mem_rd_t          rd_o,
  output logic             idle_o,
  output logic             match_o
);

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StSel  = 5'b00010,
    StRead = 5'b00100,
    StCmp  = 5'b01000,
    StDone = 5'b10000
  } seq_state_e;

  seq_state_e              state_q, state_d;
  logic [WordIdxW-1:0]     c_q, c_d;
  logic [WordIdxW:0]       w_q, w_d;
  logic [ByteIdxW-1:0]     b_q, b_d;
  logic [AddrW-1:0]        cb_q, cb_d;
  logic [AddrW-1:0]        wb_q, wb_d;
  logic [MaxWords-1:0]     used_q, used_d;

  logic [AddrW-1:0]        len_ext;
  logic [ByteIdxW-1:0]     last_byte;
  logic [RegW-1:0]         last_chunk;

  assign len_ext    = AddrW'(word_len_i);
  assign last_byte  = ByteIdxW'(word_len_i - RegW'(1));
  assign last_chunk = word_count_i - RegW'(1);

  assign rd_o.text_addr = cb_q + AddrW'(b_q);
  assign rd_o.word_addr = wb_q + AddrW'(b_q);
  assign idle_o         = (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    c_d     = c_q;
    w_d     = w_q;
    b_d     = b_q;
    cb_d    = cb_q;
    wb_d    = wb_q;
    used_d  = used_q;
    match_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          c_d     = '0;
          w_d     = '0;
          b_d     = '0;
          wb_d    = '0;
          cb_d    = base_i;
          used_d  = '0;
          state_d = StSel;
        end
      end
      StSel: begin
        // Running out of words means the current chunk has no partner.
        if (RegW'(w_q) >= word_count_i) begin
          state_d = StIdle;
        end else if (used_q[w_q[WordIdxW-1:0]]) begin
          w_d  = w_q + 1'b1;
          wb_d = wb_q + len_ext;
        end else begin
          b_d     = '0;
          state_d = StRead;
        end
      end
      StRead: begin
        state_d = StCmp;
      end
      StCmp: begin
        if (rdata_i.text_byte != rdata_i.word_byte) begin
          w_d     = w_q + 1'b1;
          wb_d    = wb_q + len_ext;
          state_d = StSel;
        end else if (b_q == last_byte) begin
          used_d[w_q[WordIdxW-1:0]] = 1'b1;
          if (RegW'(c_q) == last_chunk) begin
            state_d = StDone;
          end else begin
            c_d     = c_q + 1'b1;
            cb_d    = cb_q + len_ext;
            w_d     = '0;
            wb_d    = '0;
            state_d = StSel;
          end
        end else begin
          b_d     = b_q + 1'b1;
          state_d = StRead;
        end
      end
      StDone: begin
        if (out_free_i) begin
          match_o = 1'b1;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      c_q     <= '0;
      w_q     <= '0;
      b_q     <= '0;
      cb_q    <= '0;
      wb_q    <= '0;
      used_q  <= '0;
    end else begin
      state_q <= state_d;
      c_q     <= c_d;
      w_q     <= w_d;
      b_q     <= b_d;
      cb_q    <= cb_d;
      wb_q    <= wb_d;
      used_q  <= used_d;
    end
  end

endmodule

[tb/testbench.sv]
// Self-checking testbench for the concatenated-word substring matcher.
`timescale 1ns / 1ps

module testbench;
  import cwsm_pkg::*;

  localparam int unsigned HalfPeriod    = 4;
  localparam int unsigned ResetCycles   = 6;
  // Worst search time of the sequencer plus some margin.
  localparam int unsigned SearchLatency = MaxWords * MaxWords * (2 * MaxWordLen + 1) + 2 + 16;
  localparam int unsigned SegmentCount  = 16;
  localparam int unsigned SegmentItems  = 50;
  localparam int unsigned HoldOffCycles = 300;
  localparam logic [7:0]  SatByte       = 8'h5A;

  // Tracks word store, text window and registers, and predicts match start indexes.
  class window_match_tracker;
    logic [7:0]        word_store [StoreDepth];
    logic [7:0]        window_bytes [StoreDepth];
    int unsigned       load_ptr;
    int unsigned       text_pos;
    int unsigned       word_len;
    int unsigned       word_count;
    logic [StartW-1:0] pending_starts [$];
    int unsigned       failures;
    int unsigned       starts_checked;

    function new();
      for (int i = 0; i < StoreDepth; i++) begin
        word_store[i]   = '0;
        window_bytes[i] = '0;
      end
      load_ptr       = 0;
      text_pos       = 0;
      word_len       = 1;
      word_count     = 1;
      failures       = 0;
      starts_checked = 0;
    endfunction

    function void set_reg(logic idx, logic [RegW-1:0] value);
      int unsigned v;
      v = (value == 0) ? 1 : value;
      if (idx == RegWordLen) begin
        word_len = (v > MaxWordLen) ? MaxWordLen : v;
      end else begin
        word_count = (v > MaxWords) ? MaxWords : v;
      end
    endfunction

    // Every window chunk must claim a distinct stored word with the same bytes.
    function bit window_holds_all_words(int unsigned start);
      bit used [MaxWords];
      bit found;
      bit same;
      for (int w = 0; w < MaxWords; w++) used[w] = 1'b0;
      for (int c = 0; c < word_count; c++) begin
        found = 1'b0;
        for (int w = 0; w < word_count && !found; w++) begin
          if (!used[w]) begin
            same = 1'b1;
            for (int b = 0; b < word_len && same; b++) begin
              if (window_bytes[(start + c * word_len + b) % StoreDepth] !=
                  word_store[(w * word_len + b) % StoreDepth]) begin
                same = 1'b0;
              end
            end
            if (same) begin
              used[w] = 1'b1;
              found   = 1'b1;
            end
          end
        end
        if (!found) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void take_request(func_e f, logic [7:0] c);
      int unsigned span;
      logic [31:0] start;
      case (f)
        FuncWord: begin
          word_store[load_ptr] = c;
          load_ptr = (load_ptr + 1) % StoreDepth;
        end
        FuncRestartText: text_pos = 0;
        FuncRestartWord: load_ptr = 0;
        default: begin
          if (text_pos < MaxText) begin
            window_bytes[text_pos % StoreDepth] = c;
            text_pos++;
            span = word_len * word_count;
            if (text_pos >= span) begin
              start = text_pos - span;
              if (window_holds_all_words(start)) begin
                pending_starts.insert(pending_starts.size(), start[StartW-1:0]);
              end
            end
          end
        end
      endcase
    endfunction

    function void check_start(logic [StartW-1:0] got);
      logic [StartW-1:0] want;
      starts_checked++;
      if (pending_starts.size() == 0) begin
        $error("match_start: expected none, actual %0d", got);
        failures++;
      end else begin
        want = pending_starts.pop_front();
        if (got !== want) begin
          $error("match_start: expected %0d, actual %0d", want, got);
          failures++;
        end
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [1:0]        func_i;
  logic [7:0]        ch_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [StartW-1:0] match_start_o;
  logic              cfg_we_i;
  logic              cfg_idx_i;
  logic [RegW-1:0]   cfg_wdata_i;

  window_match_tracker tracker;
  logic [7:0]  loaded_words [MaxWords][MaxWordLen];
  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct  = 0;
  int unsigned hold_left       = 0;
  int unsigned items_sent      = 0;
  int unsigned reg_settings    = 0;

  concat_words_substring_match u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .ch_i          (ch_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .match_start_o (match_start_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #HalfPeriod clk_i = ~clk_i;

  task automatic send_request(input func_e f, input logic [7:0] c);
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= f;
    ch_i       <= c;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    tracker.take_request(f, c);
    items_sent++;
  endtask

  task automatic write_config(input logic [RegW-1:0] len, input logic [RegW-1:0] cnt);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= RegWordLen;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    tracker.set_reg(RegWordLen, len);
    cfg_idx_i   <= RegWordCount;
    cfg_wdata_i <= cnt;
    @(posedge clk_i);
    tracker.set_reg(RegWordCount, cnt);
    cfg_we_i <= 1'b0;
    reg_settings++;
  endtask

  // A request may start a search with no result, so give the sequencer time to finish.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (tracker.pending_starts.size() != 0) @(posedge clk_i);
    repeat (SearchLatency) @(posedge clk_i);
  endtask

  // Half the bytes come from a two-letter alphabet so that near misses are common.
  function automatic logic [7:0] pick_byte();
    if ($urandom_range(1) == 0) return 8'h61 + 8'($urandom_range(1));
    return 8'($urandom_range(255));
  endfunction

  task automatic load_words();
    int unsigned src;
    send_request(FuncRestartWord, pick_byte());
    for (int k = 0; k < tracker.word_count; k++) begin
      if (k > 0 && $urandom_range(2) == 0) begin
        src = $urandom_range(k - 1);
        for (int b = 0; b < MaxWordLen; b++) loaded_words[k][b] = loaded_words[src][b];
      end else begin
        for (int b = 0; b < MaxWordLen; b++) loaded_words[k][b] = pick_byte();
      end
      for (int b = 0; b < tracker.word_len; b++) send_request(FuncWord, loaded_words[k][b]);
    end
  endtask

  task automatic send_concat(input bit corrupt);
    int unsigned order [MaxWords];
    int unsigned len;
    int unsigned cnt;
    int unsigned j;
    int unsigned tmp;
    int unsigned bad;
    logic [7:0]  c;
    len = tracker.word_len;
    cnt = tracker.word_count;
    for (int i = 0; i < MaxWords; i++) order[i] = i;
    for (int i = cnt - 1; i > 0; i--) begin
      j        = $urandom_range(i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    bad = corrupt ? $urandom_range(len * cnt - 1) : len * cnt;
    for (int k = 0; k < cnt; k++) begin
      for (int b = 0; b < len; b++) begin
        c = loaded_words[order[k]][b];
        if (k * len + b == bad) c = c ^ (8'd1 << $urandom_range(7));
        send_request(FuncText, c);
      end
    end
  endtask

  task automatic send_fragment();
    int unsigned n;
    n = $urandom_range(1, tracker.word_len * tracker.word_count);
    for (int i = 0; i < n; i++) begin
      send_request(FuncText,
                   loaded_words[$urandom_range(tracker.word_count - 1)]
                               [$urandom_range(tracker.word_len - 1)]);
    end
  endtask

  task automatic run_segment(input int unsigned n);
    int unsigned first;
    int unsigned r;
    first = items_sent;
    while (items_sent - first < n) begin
      r = $urandom_range(99);
      if (r < 12) begin
        load_words();
      end else if (r < 20) begin
        send_request(FuncRestartText, 8'($urandom_range(255)));
      end else if (r < 65) begin
        if ($urandom_range(3) == 0) send_fragment();
        send_concat($urandom_range(4) == 0);
      end else if (r < 80) begin
        send_fragment();
      end else begin
        send_request(func_e'(2'($urandom_range(3))), 8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) tracker.check_start(match_start_o);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  initial begin
    logic [RegW-1:0] len;
    logic [RegW-1:0] cnt;
    tracker     = new();
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    func_i      <= FuncWord;
    ch_i        <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= RegWordLen;
    cfg_wdata_i <= '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill the whole word store once; the extra byte wraps around onto the first entry.
    for (int i = 0; i <= StoreDepth; i++) send_request(FuncWord, 8'($urandom_range(255)));

    // Single one-byte word, extremes of the byte range.
    send_request(FuncRestartWord, 8'h00);
    send_request(FuncWord, 8'hFF);
    send_request(FuncText, 8'h00);
    send_request(FuncText, 8'hFF);
    send_request(FuncRestartText, 8'hFF);
    send_request(FuncText, 8'hFF);
    wait_idle();

    // Three two-byte words with a duplicate; no result before a full window.
    write_config(4'd2, 4'd3);
    send_request(FuncRestartWord, 8'h00);
    foreach (loaded_words[k]) begin
      loaded_words[k][0] = (k == 1) ? 8'h43 : 8'h41;
      loaded_words[k][1] = (k == 1) ? 8'h44 : 8'h42;
    end
    for (int k = 0; k < 3; k++) begin
      send_request(FuncWord, loaded_words[k][0]);
      send_request(FuncWord, loaded_words[k][1]);
    end
    send_request(FuncRestartText, 8'h00);
    foreach (loaded_words[k]) begin
      if (k < 5) begin
        send_request(FuncText, loaded_words[(k == 0 || k == 3) ? 1 : 0][0]);
        send_request(FuncText, loaded_words[(k == 0 || k == 3) ? 1 : 0][1]);
      end
    end
    wait_idle();

    // A single one-byte word that every following text byte matches.
    write_config(4'd0, 4'd0);
    send_request(FuncRestartWord, 8'h00);
    send_request(FuncWord, SatByte);
    send_request(FuncRestartText, 8'h00);

    // Every text byte matches while the output is held off, so the block backs up.
    hold_left = HoldOffCycles;
    for (int i = 0; i < 40; i++) send_request(FuncText, SatByte);
    wait_idle();

    for (int s = 0; s < SegmentCount; s++) begin
      case (s)
        0: begin
          len = 4'd15;
          cnt = 4'd15;
        end
        1: begin
          len = 4'd8;
          cnt = 4'd1;
        end
        2: begin
          len = 4'd1;
          cnt = 4'd8;
        end
        3: begin
          len = 4'd9;
          cnt = 4'd0;
        end
        default: begin
          if ($urandom_range(3) == 0) begin
            len = 4'($urandom_range(15));
            cnt = 4'($urandom_range(15));
          end else begin
            len = 4'($urandom_range(4));
            cnt = 4'($urandom_range(4));
          end
        end
      endcase
      write_config(len, cnt);
      case (s % 4)
        0: begin
          sender_idle_pct = 0;
          recv_stall_pct  = 0;
        end
        1: begin
          sender_idle_pct = 48;
          recv_stall_pct  = 0;
        end
        2: begin
          sender_idle_pct = 0;
          recv_stall_pct  = 48;
        end
        default: begin
          sender_idle_pct = 18;
          recv_stall_pct  = 18;
        end
      endcase
      // Some segments keep the old words and text so the new sizes apply mid-text.
      if (s == 0 || $urandom_range(9) < 6) load_words();
      run_segment(SegmentItems);
      wait_idle();
    end

    $display("Sent %0d requests over %0d register settings and checked %0d match starts,",
             items_sent, reg_settings, tracker.starts_checked);
    $display("including duplicate words, mid-text size changes and a long output hold-off.");
    if (tracker.failures == 0 && tracker.pending_starts.size() == 0) begin
      $display("PASS concat_words_substring_match");
    end else begin
      $display("FAIL concat_words_substring_match");
    end
    $finish;
  end

  initial begin
    #80ms;
    $display("FAIL concat_words_substring_match");
    $finish;
  end

endmodule
